### hw/rtl/h2r_pkg.sv
// ----------------------------------------------------------------------------
// h2r_pkg: shared types and constants of the HSV to RGB converter
// Holds the pixel structs, the sector codes and the fixed-point constants
// that every pipeline stage derives its widths from.
// ----------------------------------------------------------------------------
package h2r_pkg;

  // Channel width and full-scale value
  localparam int unsigned ColorBits = 8;
  localparam int unsigned Full      = (1 << ColorBits) - 1;

  // Hue in whole degrees, split into 60-degree sectors
  localparam int unsigned HueBits   = 9;
  localparam int unsigned SectorDeg = 60;
  localparam int unsigned RemBits   = $clog2(SectorDeg);
  localparam int unsigned MaxCount  = ((1 << HueBits) - 1) / SectorDeg;
  localparam int unsigned CountBits = $clog2(MaxCount + 1);

  // Common denominator of q and t
  localparam int unsigned Den       = SectorDeg * Full;
  localparam int unsigned DenBits   = $clog2(Den + 1);

  // Widths of the scaled numerators
  localparam int unsigned XpBits    = 2 * ColorBits;
  localparam int unsigned XqBits    = ColorBits + DenBits;

  // Sector codes, named by the hue range they cover; hue past 359 folds
  // into the magenta-red sector
  typedef enum logic [2:0] {
    SEC_RY = 3'd0,
    SEC_YG = 3'd1,
    SEC_GC = 3'd2,
    SEC_CB = 3'd3,
    SEC_BM = 3'd4,
    SEC_MR = 3'd5
  } sector_e;

  typedef struct packed {
    logic [HueBits-1:0]   hue;
    logic [ColorBits-1:0] saturation;
    logic [ColorBits-1:0] brightness;
  } hsv_t;

  typedef struct packed {
    logic [ColorBits-1:0] red;
    logic [ColorBits-1:0] green;
    logic [ColorBits-1:0] blue;
  } rgb_t;

  // Control that travels alongside the data through the stages
  typedef struct packed {
    logic    valid;
    sector_e sector;
  } ctl_t;

endpackage

### hw/rtl/h2r_decode.sv
// ----------------------------------------------------------------------------
// h2r_decode: hue sector decode stage
// Splits the hue into a sector code and the remainder within the sector.
// ----------------------------------------------------------------------------
module h2r_decode (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  h2r_pkg::hsv_t                       pixel_i,
  output h2r_pkg::ctl_t                       ctl_o,
  output logic [h2r_pkg::RemBits-1:0]         rem_o,
  output logic [h2r_pkg::ColorBits-1:0]       sat_o,
  output logic [h2r_pkg::ColorBits-1:0]       bri_o
);

  logic [h2r_pkg::CountBits-1:0] count;
  logic [h2r_pkg::HueBits-1:0]   base;
  h2r_pkg::ctl_t                 ctl_d, ctl_q;
  logic [h2r_pkg::RemBits-1:0]   rem_d, rem_q;
  logic [h2r_pkg::ColorBits-1:0] sat_q, bri_q;

  // Count the sector thresholds the hue has passed
  always_comb begin
    count = '0;
    for (int k = 1; k <= int'(h2r_pkg::MaxCount); k++) begin
      if (pixel_i.hue >= h2r_pkg::HueBits'(k * h2r_pkg::SectorDeg)) begin
        count = h2r_pkg::CountBits'(k);
      end
    end
  end

  assign base  = h2r_pkg::HueBits'(count * h2r_pkg::SectorDeg);
  assign rem_d = h2r_pkg::RemBits'(pixel_i.hue - base);

  always_comb begin
    ctl_d.valid = valid_i;
    case (count)
      h2r_pkg::CountBits'(0): ctl_d.sector = h2r_pkg::SEC_RY;
      h2r_pkg::CountBits'(1): ctl_d.sector = h2r_pkg::SEC_YG;
      h2r_pkg::CountBits'(2): ctl_d.sector = h2r_pkg::SEC_GC;
      h2r_pkg::CountBits'(3): ctl_d.sector = h2r_pkg::SEC_CB;
      h2r_pkg::CountBits'(4): ctl_d.sector = h2r_pkg::SEC_BM;
      default:                ctl_d.sector = h2r_pkg::SEC_MR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    sat_q <= pixel_i.saturation;
    bri_q <= pixel_i.brightness;
  end

  assign ctl_o = ctl_q;
  assign rem_o = rem_q;
  assign sat_o = sat_q;
  assign bri_o = bri_q;

endmodule

### hw/rtl/h2r_coef.sv
// ----------------------------------------------------------------------------
// h2r_coef: coefficient and scaling stages
// Forms the p, q and t coefficients from saturation and remainder, then
// scales each by the brightness. Two register stages.
// ----------------------------------------------------------------------------
module h2r_coef (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  h2r_pkg::ctl_t                       ctl_i,
  input  logic [h2r_pkg::RemBits-1:0]         rem_i,
  input  logic [h2r_pkg::ColorBits-1:0]       sat_i,
  input  logic [h2r_pkg::ColorBits-1:0]       bri_i,
  output h2r_pkg::ctl_t                       ctl_o,
  output logic [h2r_pkg::ColorBits-1:0]       bri_o,
  output logic [h2r_pkg::XpBits-1:0]          xp_o,
  output logic [h2r_pkg::XqBits-1:0]          xq_o,
  output logic [h2r_pkg::XqBits-1:0]          xt_o
);

  localparam int unsigned SrBits = h2r_pkg::ColorBits + h2r_pkg::RemBits + 1;

  logic [h2r_pkg::RemBits:0]     comp;
  logic [SrBits-1:0]             s_rem, s_comp;
  logic [h2r_pkg::ColorBits-1:0] ap_d, ap_q;
  logic [h2r_pkg::DenBits-1:0]   aq_d, aq_q, at_d, at_q;
  logic [h2r_pkg::ColorBits-1:0] bri2_q, bri3_q;
  h2r_pkg::ctl_t                 ctl2_q, ctl3_q;
  logic [h2r_pkg::XpBits-1:0]    xp_q;
  logic [h2r_pkg::XqBits-1:0]    xq_q, xt_q;

  // Coefficients: FULL - s, DEN - s*r, DEN - s*(60 - r)
  assign comp   = (h2r_pkg::RemBits+1)'(h2r_pkg::SectorDeg) - {1'b0, rem_i};
  assign s_rem  = SrBits'(sat_i) * SrBits'(rem_i);
  assign s_comp = SrBits'(sat_i) * SrBits'(comp);
  assign ap_d   = h2r_pkg::ColorBits'(h2r_pkg::Full) - sat_i;
  assign aq_d   = h2r_pkg::DenBits'(h2r_pkg::Den) - h2r_pkg::DenBits'(s_rem);
  assign at_d   = h2r_pkg::DenBits'(h2r_pkg::Den) - h2r_pkg::DenBits'(s_comp);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl2_q <= '0;
      ctl3_q <= '0;
    end else begin
      ctl2_q <= ctl_i;
      ctl3_q <= ctl2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ap_q   <= ap_d;
    aq_q   <= aq_d;
    at_q   <= at_d;
    bri2_q <= bri_i;
    // Scale by brightness
    xp_q   <= h2r_pkg::XpBits'(bri2_q) * h2r_pkg::XpBits'(ap_q);
    xq_q   <= h2r_pkg::XqBits'(bri2_q) * h2r_pkg::XqBits'(aq_q);
    xt_q   <= h2r_pkg::XqBits'(bri2_q) * h2r_pkg::XqBits'(at_q);
    bri3_q <= bri2_q;
  end

  assign ctl_o = ctl3_q;
  assign bri_o = bri3_q;
  assign xp_o  = xp_q;
  assign xq_o  = xq_q;
  assign xt_o  = xt_q;

endmodule

### hw/rtl/h2r_const_div.sv
// ----------------------------------------------------------------------------
// h2r_const_div: floor division by a constant
// Multiplies by a rounded-up reciprocal, registers the product and takes
// the quotient from its upper bits. Exact for every input of IN_W bits.
// ----------------------------------------------------------------------------
module h2r_const_div #(
  parameter int unsigned IN_W    = 16,
  parameter int unsigned OUT_W   = 8,
  parameter int unsigned DIVISOR = 255
) (
  input  logic             clk_i,
  input  logic [IN_W-1:0]  x_i,
  output logic [OUT_W-1:0] quot_o
);

  // Shift chosen so that xmax * divisor <= 2^Shift, which makes the
  // rounded-up reciprocal exact over the whole input range
  localparam longint unsigned XMax     = (64'd1 << IN_W) - 64'd1;
  localparam int unsigned     Shift    = $clog2(XMax * DIVISOR);
  localparam longint unsigned Recip    = ((64'd1 << Shift) + DIVISOR - 1) / DIVISOR;
  localparam int unsigned     RecipBits = $clog2(Recip + 1);
  localparam int unsigned     ProdBits = IN_W + RecipBits;

  logic [ProdBits-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= ProdBits'(x_i) * ProdBits'(Recip);
  end

  assign quot_o = prod_q[Shift +: OUT_W];

endmodule

### hw/rtl/hsv_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter: HSV to RGB pixel conversion pipeline
// Path: a pixel taken at one edge passes the decode, coefficient, scaling,
//   divider and output registers and shows on rgb_o, with done_o high, for a single cycle.
// Throughput: one pixel per cycle; busy_o is always low, the pipeline
//   never stalls and results must be taken when strobed.
// Reset clears the stage control (valid and sector) only; nothing is in flight after it.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  h2r_pkg::hsv_t pixel_i,
  output logic          done_o,
  output h2r_pkg::rgb_t rgb_o
);

  // Stage 1 outputs: sector decode
  h2r_pkg::ctl_t                 ctl1;
  logic [h2r_pkg::RemBits-1:0]   rem1;
  logic [h2r_pkg::ColorBits-1:0] sat1, bri1;

  // Stage 3 outputs: scaled numerators
  h2r_pkg::ctl_t                 ctl3;
  logic [h2r_pkg::ColorBits-1:0] bri3;
  logic [h2r_pkg::XpBits-1:0]    xp3;
  logic [h2r_pkg::XqBits-1:0]    xq3, xt3;

  // Stage 4: reciprocal products, with control and brightness held alongside
  logic [h2r_pkg::ColorBits-1:0] p4, q4, t4;
  h2r_pkg::ctl_t                 ctl4_q;
  logic [h2r_pkg::ColorBits-1:0] bri4_q;

  // Stage 5: output register
  h2r_pkg::rgb_t                 rgb_d, rgb_q;
  logic                          done_q;

  // No back-pressure anywhere: take a pixel every cycle
  assign busy_o = 1'b0;

  h2r_decode u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i),
    .pixel_i (pixel_i),
    .ctl_o   (ctl1),
    .rem_o   (rem1),
    .sat_o   (sat1),
    .bri_o   (bri1)
  );

  h2r_coef u_coef (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl1),
    .rem_i  (rem1),
    .sat_i  (sat1),
    .bri_i  (bri1),
    .ctl_o  (ctl3),
    .bri_o  (bri3),
    .xp_o   (xp3),
    .xq_o   (xq3),
    .xt_o   (xt3)
  );

  // p = floor(V*(FULL-S)/FULL)
  h2r_const_div #(
    .IN_W    (h2r_pkg::XpBits),
    .OUT_W   (h2r_pkg::ColorBits),
    .DIVISOR (h2r_pkg::Full)
  ) u_div_p (
    .clk_i  (clk_i),
    .x_i    (xp3),
    .quot_o (p4)
  );

  // q = floor(V*(DEN-S*r)/DEN)
  h2r_const_div #(
    .IN_W    (h2r_pkg::XqBits),
    .OUT_W   (h2r_pkg::ColorBits),
    .DIVISOR (h2r_pkg::Den)
  ) u_div_q (
    .clk_i  (clk_i),
    .x_i    (xq3),
    .quot_o (q4)
  );

  // t = floor(V*(DEN-S*(60-r))/DEN)
  h2r_const_div #(
    .IN_W    (h2r_pkg::XqBits),
    .OUT_W   (h2r_pkg::ColorBits),
    .DIVISOR (h2r_pkg::Den)
  ) u_div_t (
    .clk_i  (clk_i),
    .x_i    (xt3),
    .quot_o (t4)
  );

  // Hold control and brightness level with the divider products
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl4_q <= '0;
    end else begin
      ctl4_q <= ctl3;
    end
  end

  always_ff @(posedge clk_i) begin
    bri4_q <= bri3;
  end

  // Route v, p, q, t to the channels by sector. Zero saturation needs no
  // special path: p, q and t all equal v then, giving gray.
  always_comb begin
    case (ctl4_q.sector)
      h2r_pkg::SEC_RY: begin
        rgb_d = '{red: bri4_q, green: t4, blue: p4};
      end
      h2r_pkg::SEC_YG: begin
        rgb_d = '{red: q4, green: bri4_q, blue: p4};
      end
      h2r_pkg::SEC_GC: begin
        rgb_d = '{red: p4, green: bri4_q, blue: t4};
      end
      h2r_pkg::SEC_CB: begin
        rgb_d = '{red: p4, green: q4, blue: bri4_q};
      end
      h2r_pkg::SEC_BM: begin
        rgb_d = '{red: t4, green: p4, blue: bri4_q};
      end
      default: begin
        rgb_d = '{red: bri4_q, green: p4, blue: q4};
      end
    endcase
  end

  // Output register: the strobe lasts exactly one cycle per item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctl4_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    rgb_q <= rgb_d;
  end

  assign done_o = done_q;
  assign rgb_o  = rgb_q;

  // Every accepted item comes out as a done_o strobe
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##5 done_o)
    else $error("item accepted without a result five cycles later");

  // No result without a matching item started on start_i
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, 5))
    else $error("result strobed with no matching item");

  // Zero saturation yields gray at the input brightness
  a_gray: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && ($past(pixel_i.saturation, 5) == '0)) |->
      ((rgb_o.red == $past(pixel_i.brightness, 5)) &&
       (rgb_o.green == $past(pixel_i.brightness, 5)) &&
       (rgb_o.blue == $past(pixel_i.brightness, 5))))
    else $error("zero saturation did not give gray");

  // One channel always carries the brightness itself
  a_max_channel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((rgb_o.red == $past(pixel_i.brightness, 5)) ||
                (rgb_o.green == $past(pixel_i.brightness, 5)) ||
                (rgb_o.blue == $past(pixel_i.brightness, 5))))
    else $error("no channel equals the brightness");

endmodule

### verif/tb_hsv_to_rgb_converter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hsv_to_rgb_converter: self-checking bench for the HSV to RGB converter
// Drives pixels through the start/busy handshake with random gaps and
// back-to-back bursts. Every accepted pixel is converted by an integer model
// of the floor formulas for p, q and t. The expected colors are queued, and
// each done_o strobe is checked channel by channel against the oldest one.
// ----------------------------------------------------------------------------
module tb_hsv_to_rgb_converter;

  localparam int unsigned ClkPeriod  = 12;
  localparam int unsigned RandItems  = 1900;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainWait  = 10;

  logic           clk_i;
  logic           rst_ni;
  logic           start_i;
  logic           busy_o;
  h2r_pkg::hsv_t  pixel_i;
  logic           done_o;
  h2r_pkg::rgb_t  rgb_o;

  // Colors still owed by the pipeline, oldest first
  h2r_pkg::rgb_t rgb_expect_q[$];
  h2r_pkg::rgb_t rgb_expected;
  int unsigned   error_count;
  int unsigned   cycle_count;
  // When set, the sender drops its idle gaps and streams one item per cycle while busy_o stays low
  bit            burst_mode;

  hsv_to_rgb_converter uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .pixel_i (pixel_i),
    .done_o  (done_o),
    .rgb_o   (rgb_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // Convert one pixel: split the hue into sector and remainder, form the
  // floored p, q and t on the 0..Full scale and route them by sector.
  function automatic h2r_pkg::rgb_t hsv_predict(h2r_pkg::hsv_t px);
    longint unsigned               hue_deg, sat, val, sec_idx, rem, den, p, q, t;
    logic [h2r_pkg::ColorBits-1:0] v_c, p_c, q_c, t_c;
    h2r_pkg::sector_e              sec;
    h2r_pkg::rgb_t                 rgb;
    hue_deg = px.hue;
    sat     = px.saturation;
    val     = px.brightness;
    sec_idx = hue_deg / h2r_pkg::SectorDeg;
    rem     = hue_deg % h2r_pkg::SectorDeg;
    den     = h2r_pkg::SectorDeg * h2r_pkg::Full;
    p = (val * (h2r_pkg::Full - sat)) / h2r_pkg::Full;
    q = (val * (den - sat * rem)) / den;
    t = (val * (den - sat * (h2r_pkg::SectorDeg - rem))) / den;
    v_c = val[h2r_pkg::ColorBits-1:0];
    p_c = p[h2r_pkg::ColorBits-1:0];
    q_c = q[h2r_pkg::ColorBits-1:0];
    t_c = t[h2r_pkg::ColorBits-1:0];
    // Fold hues past 359 into the last sector
    if (sec_idx > h2r_pkg::SEC_MR) begin
      sec = h2r_pkg::SEC_MR;
    end else begin
      sec = h2r_pkg::sector_e'(sec_idx[2:0]);
    end
    if (sat == 0) begin
      rgb = '{red: v_c, green: v_c, blue: v_c};
    end else begin
      case (sec)
        h2r_pkg::SEC_RY: rgb = '{red: v_c, green: t_c, blue: p_c};
        h2r_pkg::SEC_YG: rgb = '{red: q_c, green: v_c, blue: p_c};
        h2r_pkg::SEC_GC: rgb = '{red: p_c, green: v_c, blue: t_c};
        h2r_pkg::SEC_CB: rgb = '{red: p_c, green: q_c, blue: v_c};
        h2r_pkg::SEC_BM: rgb = '{red: t_c, green: p_c, blue: v_c};
        default:         rgb = '{red: v_c, green: p_c, blue: q_c};
      endcase
    end
    return rgb;
  endfunction

  task automatic compare_channel(input string chan,
                                 input logic [h2r_pkg::ColorBits-1:0] exp_val,
                                 input logic [h2r_pkg::ColorBits-1:0] act_val);
    if (act_val !== exp_val) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, chan, exp_val, act_val);
      error_count++;
    end
  endtask

  // Scoreboard: sample at the edge, so all values are the pre-edge ones.
  // Check the strobed color first, then queue the prediction for a pixel
  // taken at this edge; the pipeline latency keeps the two apart.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        if (rgb_expect_q.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %0d/%0d/%0d",
                   $time, rgb_o.red, rgb_o.green, rgb_o.blue);
          error_count++;
        end else begin
          rgb_expected = rgb_expect_q.pop_front();
          compare_channel("red", rgb_expected.red, rgb_o.red);
          compare_channel("green", rgb_expected.green, rgb_o.green);
          compare_channel("blue", rgb_expected.blue, rgb_o.blue);
        end
      end
      if (start_i && !busy_o) begin
        rgb_expect_q.push_back(hsv_predict(pixel_i));
      end
    end
  end

  // Watchdog: end the run if it hangs
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout, %0d results still outstanding", $time, rgb_expect_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Send one item. Hold start low for a random gap, then present the pixel
  // and advance until it is taken. Start is left high on return, so a
  // following item without a gap keeps it high without a second assignment.
  task automatic send_pixel(input logic [h2r_pkg::HueBits-1:0] hue,
                            input logic [h2r_pkg::ColorBits-1:0] sat,
                            input logic [h2r_pkg::ColorBits-1:0] val);
    int unsigned gap;
    gap = burst_mode ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i            <= 1'b1;
    pixel_i.hue        <= hue;
    pixel_i.saturation <= sat;
    pixel_i.brightness <= val;
    do @(posedge clk_i); while (busy_o);
  endtask

  // Field extremes and the pure primaries and secondaries
  task automatic test_extremes();
    send_pixel(9'd0, 8'd0, 8'd0);
    send_pixel(9'd359, 8'd255, 8'd255);
    send_pixel(9'd0, 8'd255, 8'd255);
    send_pixel(9'd120, 8'd255, 8'd255);
    send_pixel(9'd240, 8'd255, 8'd255);
    send_pixel(9'd60, 8'd255, 8'd255);
    send_pixel(9'd180, 8'd255, 8'd255);
    send_pixel(9'd300, 8'd255, 8'd255);
    send_pixel(9'd90, 8'd255, 8'd0);
  endtask

  // Zero saturation must give gray at the input brightness
  task automatic test_gray();
    send_pixel(9'd200, 8'd0, 8'd128);
    send_pixel(9'd37, 8'd0, 8'd255);
    send_pixel(9'd511, 8'd0, 8'd77);
  endtask

  // Hue at the last degree of the first five sectors and just inside the magenta-red one, with a partial saturation
  task automatic test_sector_edges();
    send_pixel(9'd59, 8'd170, 8'd200);
    send_pixel(9'd119, 8'd170, 8'd200);
    send_pixel(9'd179, 8'd85, 8'd200);
    send_pixel(9'd239, 8'd85, 8'd200);
    send_pixel(9'd299, 8'd1, 8'd254);
    send_pixel(9'd301, 8'd254, 8'd1);
  endtask

  // Hue beyond 359 folds into the magenta-red sector
  task automatic test_hue_overrange();
    send_pixel(9'd360, 8'd170, 8'd255);
    send_pixel(9'd420, 8'd200, 8'd255);
    send_pixel(9'd479, 8'd99, 8'd180);
    send_pixel(9'd511, 8'd255, 8'd255);
  endtask

  // Random pixels in blocks of 50, each block picked at random as gapped or burst traffic
  task automatic test_random();
    logic [h2r_pkg::HueBits-1:0]   hue;
    logic [h2r_pkg::ColorBits-1:0] sat;
    logic [h2r_pkg::ColorBits-1:0] val;
    for (int unsigned i = 0; i < RandItems; i++) begin
      if (i % 50 == 0) begin
        burst_mode = ($urandom_range(0, 2) == 0);
      end
      // Keep most hues in range, but cover the whole 9-bit field too
      if ($urandom_range(0, 9) == 0) begin
        hue = h2r_pkg::HueBits'($urandom_range(360, 511));
      end else begin
        hue = h2r_pkg::HueBits'($urandom_range(0, 359));
      end
      case ($urandom_range(0, 9))
        0:       sat = '0;
        1:       sat = '1;
        default: sat = h2r_pkg::ColorBits'($urandom_range(0, h2r_pkg::Full));
      endcase
      case ($urandom_range(0, 9))
        0:       val = '0;
        1:       val = '1;
        default: val = h2r_pkg::ColorBits'($urandom_range(0, h2r_pkg::Full));
      endcase
      send_pixel(hue, sat, val);
    end
    burst_mode = 1'b0;
  endtask

  initial begin
    error_count = 0;
    cycle_count = 0;
    burst_mode  = 1'b0;
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    pixel_i     = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_extremes();
    test_gray();
    test_sector_edges();
    test_hue_overrange();
    test_random();

    // Drop start and drain the pipeline
    start_i <= 1'b0;
    while (rgb_expect_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
